// ===== rtl/kiss_frame_deframer_addr_filter_unit_macros.svh =====
// Assertion macros used by the port-level checker of the KISS deframer.
// No dependencies; include by bare file name inside a module body.
`ifndef KISS_FRAME_DEFRAMER_ADDR_FILTER_UNIT_MACROS_SVH
`define KISS_FRAME_DEFRAMER_ADDR_FILTER_UNIT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define KFD_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kfd assertion failed");

// Clocked assertion on the usual clk_i / rst_ni pair.
`define KFD_ASSERT(lbl, prop) `KFD_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/kfd_pkg.sv =====
// Shared constants and types for the KISS deframer with address filter.
// No dependencies; imported by the interfaces, the modules and the checker.
package kfd_pkg;

  localparam logic [7:0] Fend  = 8'hC0;
  localparam logic [7:0] Fesc  = 8'hDB;
  localparam logic [7:0] Tfend = 8'hDC;
  localparam logic [7:0] Tfesc = 8'hDD;

  typedef enum logic [1:0] {
    ActNone     = 2'd0,
    ActAppend   = 2'd1,
    ActComplete = 2'd2,
    ActDiscard  = 2'd3
  } action_e;

  typedef enum logic {
    CfgOwnAddr = 1'b0,
    CfgSrcAddr = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] data_byte;
  } result_t;

endpackage

// ===== rtl/kfd_if.sv =====
// Handshake channels of the KISS deframer: byte input, result output, config write.
// Depends on kfd_pkg.
interface kfd_byte_if import kfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kfd_result_if import kfd_pkg::*; ();
  logic       valid;
  logic       ready;
  action_e    action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface kfd_cfg_if import kfd_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_reg_e   reg_index;
  logic [7:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// ===== rtl/kfd_fsm.sv =====
// Frame state machine: address filter, escape decoding and result register.
// Depends on kfd_pkg.
module kfd_fsm import kfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] own_addr_i,
  input  logic [7:0] src_addr_i,
  output result_t    result_o
);

  typedef enum logic [2:0] {
    StIdle   = 3'd0,
    StSrc    = 3'd1,
    StReject = 3'd2,
    StData   = 3'd3,
    StEsc    = 3'd4
  } state_e;

  state_e  state_q, state_d;
  result_t result_q, result_d;

  always_comb begin
    state_d            = state_q;
    result_d.action    = ActNone;
    result_d.data_byte = 8'h00;
    if (byte_i == Fend) begin
      // FEND always ends the frame; only an accepted one completes
      unique case (state_q)
        StSrc, StData, StEsc: result_d.action = ActComplete;
        default:              result_d.action = ActDiscard;
      endcase
      state_d = StIdle;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (byte_i == own_addr_i) begin
            state_d            = StSrc;
            result_d.action    = ActAppend;
            result_d.data_byte = byte_i;
          end else begin
            state_d = StReject;
          end
        end
        StSrc: begin
          if (byte_i == src_addr_i) begin
            state_d            = StData;
            result_d.action    = ActAppend;
            result_d.data_byte = byte_i;
          end else begin
            state_d = StReject;
          end
        end
        StData: begin
          if (byte_i == Fesc) begin
            state_d = StEsc;
          end else begin
            result_d.action    = ActAppend;
            result_d.data_byte = byte_i;
          end
        end
        StEsc: begin
          if (byte_i == Tfend) begin
            state_d            = StData;
            result_d.action    = ActAppend;
            result_d.data_byte = Fend;
          end else if (byte_i == Tfesc) begin
            state_d            = StData;
            result_d.action    = ActAppend;
            result_d.data_byte = Fesc;
          end else begin
            state_d = StReject;
          end
        end
        default: begin
          // rejected frame: drop every byte up to the closing FEND
          state_d         = StReject;
          result_d.action = ActDiscard;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= StIdle;
      result_q.action    <= ActNone;
      result_q.data_byte <= 8'h00;
    end else if (step_i) begin
      state_q  <= state_d;
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ===== rtl/kiss_frame_deframer_addr_filter_unit.sv =====
// KISS deframer with address filter: one result beat per received byte beat.
// Path: an accepted byte lands in the input register; its result loads the result register
// once that register is free or draining.
// Throughput: one byte per cycle; input stalls only while the result register is held.
// Reset: clears frame state to waiting-for-destination, empties both stages,
// and sets own and source address registers to zero. Config is always ready.
module kiss_frame_deframer_addr_filter_unit import kfd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  kfd_byte_if.sink     rx_i,
  kfd_result_if.source res_o,
  kfd_cfg_if.sink      cfg_i
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] own_addr_q, src_addr_q;
  logic       rx_beat, res_beat, step;
  result_t    result;

  // advance the input stage whenever the result register is free or draining
  assign step     = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || step;
  assign rx_beat  = rx_i.valid && rx_i.ready;
  assign res_beat = out_valid_q && res_o.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_beat) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (res_beat) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_beat) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= 8'h00;
      src_addr_q <= 8'h00;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CfgOwnAddr: own_addr_q <= cfg_i.data;
        CfgSrcAddr: src_addr_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  kfd_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .own_addr_i (own_addr_q),
    .src_addr_i (src_addr_q),
    .result_o   (result)
  );

  assign res_o.valid     = out_valid_q;
  assign res_o.action    = result.action;
  assign res_o.data_byte = result.data_byte;

endmodule

// ===== rtl/kfd_checker.sv =====
// Port-level checker for the KISS deframer, bound to the top level.
// Depends on kfd_pkg and kiss_frame_deframer_addr_filter_unit_macros.svh.
module kfd_checker import kfd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input action_e    res_action,
  input logic [7:0] res_data_byte
);

  `include "kiss_frame_deframer_addr_filter_unit_macros.svh"

  // only appends carry a byte
  `KFD_ASSERT(a_data_zero, res_valid && res_action != ActAppend |-> res_data_byte == 8'h00)
  // input backpressure only comes from a held result
  `KFD_ASSERT(a_stall_cause, !rx_ready |-> res_valid && !res_ready)
  // a held result beat keeps its payload
  `KFD_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_action) && $stable(res_data_byte))
  // an accepted byte into an empty output shows a result beat after the input and result registers
  `KFD_ASSERT(a_latency, rx_valid && rx_ready && !res_valid |=> ##1 res_valid)

endmodule

bind kiss_frame_deframer_addr_filter_unit kfd_checker u_kfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_valid      (rx_i.valid),
  .rx_ready      (rx_i.ready),
  .res_valid     (res_o.valid),
  .res_ready     (res_o.ready),
  .res_action    (res_o.action),
  .res_data_byte (res_o.data_byte)
);

// ===== dv/kfd_deframe_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the KISS deframer: watches the byte, result and config channels,
// predicts one result per byte beat and compares. Depends on kfd_pkg and kfd_if.sv.
module kfd_deframe_checker import kfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  kfd_byte_if         rx_i,
  kfd_result_if       res_i,
  kfd_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned frames_o
);

  typedef enum logic [2:0] {
    WaitDest = 3'd0,
    WaitSrc  = 3'd1,
    Rejected = 3'd2,
    InData   = 3'd3,
    InEscape = 3'd4
  } deframe_state_e;

  deframe_state_e frame_st;
  logic [7:0]     own_addr;
  logic [7:0]     src_addr;
  result_t        expected_q[$];
  result_t        want;

  // Advance the frame state by one received byte and return the action it causes.
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    r.action    = ActNone;
    r.data_byte = 8'h00;
    if (b == Fend) begin
      if (frame_st == WaitDest || frame_st == Rejected) r.action = ActDiscard;
      else r.action = ActComplete;
      frame_st = WaitDest;
    end else begin
      case (frame_st)
        WaitDest: begin
          if (b == own_addr) begin
            frame_st    = WaitSrc;
            r.action    = ActAppend;
            r.data_byte = b;
          end else begin
            frame_st = Rejected;
          end
        end
        WaitSrc: begin
          if (b == src_addr) begin
            frame_st    = InData;
            r.action    = ActAppend;
            r.data_byte = b;
          end else begin
            frame_st = Rejected;
          end
        end
        InData: begin
          if (b == Fesc) begin
            frame_st = InEscape;
          end else begin
            r.action    = ActAppend;
            r.data_byte = b;
          end
        end
        InEscape: begin
          if (b == Tfend) begin
            frame_st    = InData;
            r.action    = ActAppend;
            r.data_byte = Fend;
          end else if (b == Tfesc) begin
            frame_st    = InData;
            r.action    = ActAppend;
            r.data_byte = Fesc;
          end else begin
            frame_st = Rejected;
          end
        end
        default: begin
          r.action = ActDiscard;
          frame_st = Rejected;
        end
      endcase
    end
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    frames_o     = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_st = WaitDest;
      own_addr = 8'h00;
      src_addr = 8'h00;
      expected_q.delete();
    end else begin
      // compare before pushing so a result can never match a byte of the same edge
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no byte outstanding: action %0d data_byte 0x%02h",
                 res_i.action, res_i.data_byte);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (res_i.action !== want.action) begin
            $error("action mismatch: expected %0d, got %0d", want.action, res_i.action);
            fail_count_o++;
          end
          if (res_i.data_byte !== want.data_byte) begin
            $error("data_byte mismatch: expected 0x%02h, got 0x%02h",
                   want.data_byte, res_i.data_byte);
            fail_count_o++;
          end
          if (want.action == ActComplete) frames_o++;
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.reg_index)
          CfgOwnAddr: own_addr = cfg_i.data;
          CfgSrcAddr: src_addr = cfg_i.data;
          default: ;
        endcase
      end
      if (rx_i.valid && rx_i.ready) expected_q.push_back(deframe_byte(rx_i.rx_byte));
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== dv/tb_kiss_frame_deframer_addr_filter_unit.sv =====
`timescale 1ns / 1ps
// Top of the KISS deframer testbench: clock, reset, byte and config stimulus, verdict.
// Depends on kfd_pkg, kfd_if.sv, the deframer RTL and kfd_deframe_checker.
module tb_kiss_frame_deframer_addr_filter_unit;
  import kfd_pkg::*;

  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseBytes   = 200;
  localparam logic [7:0]  DirOwn       = 8'h5A;
  localparam logic [7:0]  DirSrc       = 8'hA5;
  localparam logic [7:0]  DirectedSeq [25] = '{
    Fend,                                                  // flush while idle
    DirOwn, DirSrc, 8'h00, 8'hFF, Fesc, Tfend, Fesc, Tfesc,
    Fesc, Fend,                                            // escape right before close
    DirOwn, Fend,                                          // close after destination only
    8'h33, 8'h44, Fend,                                    // wrong destination
    DirOwn, 8'h00, Fend,                                   // wrong source
    DirOwn, DirSrc, Fesc, 8'h12, 8'h13, Fend               // bad escape
  };

  logic        clk_i;
  logic        rst_ni;
  bit          gaps_on;
  logic [7:0]  own_set;
  logic [7:0]  src_set;
  int unsigned bytes_sent;
  int unsigned settings_used;
  int unsigned phase_start;
  int unsigned idle_cycles;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned frames_done;

  kfd_byte_if   rx_if ();
  kfd_result_if res_if ();
  kfd_cfg_if    cfg_if ();

  kiss_frame_deframer_addr_filter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  kfd_deframe_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .frames_o     (frames_done)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bias payload toward the framing and escape codes.
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = Fend;
      1: b = Fesc;
      2: b = Tfend;
      3: b = Tfesc;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.data      <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // Drain all outstanding results, then write both address registers.
  task automatic drain_and_configure(input logic [7:0] own, input logic [7:0] src);
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(CfgOwnAddr, own);
    write_reg(CfgSrcAddr, src);
    cfg_if.valid <= 1'b0;
    own_set = own;
    src_set = src;
    settings_used++;
  endtask

  // Mostly well-formed frames; occasionally a wrong address, an early close,
  // a broken escape or a dangling escape before the closing FEND.
  task automatic send_frame();
    int unsigned len;
    logic [7:0]  b;
    send_byte(($urandom_range(0, 9) == 0) ? payload_byte() : own_set);
    if ($urandom_range(0, 19) == 0) begin
      send_byte(Fend);
      return;
    end
    send_byte(($urandom_range(0, 9) == 0) ? payload_byte() : src_set);
    len = $urandom_range(0, 12);
    repeat (len) begin
      b = payload_byte();
      if ($urandom_range(0, 39) == 0) begin
        send_byte(Fesc);
        send_byte(payload_byte());
      end else if (b == Fend) begin
        send_byte(Fesc);
        send_byte(Tfend);
      end else if (b == Fesc) begin
        send_byte(Fesc);
        send_byte(Tfesc);
      end else begin
        send_byte(b);
      end
    end
    if ($urandom_range(0, 19) == 0) send_byte(Fesc);
    send_byte(Fend);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(payload_byte());
  endtask

  // Result sink: random stall bursts while gaps are enabled.
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
          $display("Timeout: no beat accepted for %0d cycles", StallLimit);
          $display("FAIL kiss_frame_deframer_addr_filter_unit");
          $finish;
        end
      end
    end
  end

  initial begin
    gaps_on          = 1'b1;
    own_set          = 8'h00;
    src_set          = 8'h00;
    bytes_sent       = 0;
    settings_used    = 0;
    idle_cycles      = 0;
    rst_ni           <= 1'b0;
    rx_if.valid      <= 1'b0;
    rx_if.rx_byte    <= 8'h00;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= CfgOwnAddr;
    cfg_if.data      <= 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drain_and_configure(DirOwn, DirSrc);
    foreach (DirectedSeq[i]) send_byte(DirectedSeq[i]);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: drain_and_configure(8'h00, 8'h00);
        1: drain_and_configure(8'hFF, 8'hFF);
        2: drain_and_configure(Fesc, Tfend);
        default: drain_and_configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      // final phases run at full rate on both sides
      gaps_on     = (p < PhaseCount - 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        if ($urandom_range(0, 4) != 0) send_frame();
        else send_noise();
      end
    end

    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d received bytes under %0d address settings, %0d frames completed.",
             bytes_sent, settings_used, frames_done);
    if (fail_count == 0) begin
      $display("PASS kiss_frame_deframer_addr_filter_unit");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("FAIL kiss_frame_deframer_addr_filter_unit");
    end
    $finish;
  end

endmodule

// ===== kiss_frame_deframer_addr_filter_unit.f =====
+incdir+rtl
rtl/kfd_pkg.sv
rtl/kfd_if.sv
rtl/kfd_fsm.sv
rtl/kiss_frame_deframer_addr_filter_unit.sv
rtl/kfd_checker.sv
dv/kfd_deframe_checker.sv
dv/tb_kiss_frame_deframer_addr_filter_unit.sv
